### rtl/slfr_pkg.sv
// Package for the sync/length frame receiver.
// Holds the header position type, the payload and command structs and shared constants.
// No dependencies; every other file of the block but slfr_stream_if refers to it by scoped names.
`default_nettype none

package slfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int HDR_BYTES   = 5;
    localparam int STORE_BYTES = 3;
    localparam int REM_W       = 17;
    localparam int HDR_CNT_W   = 3;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [2:0] {
        POS_HUNT_FIRST  = 3'd0,
        POS_HUNT_SECOND = 3'd1,
        POS_TYPE        = 3'd2,
        POS_LEN_HI      = 3'd3,
        POS_LEN_LO      = 3'd4,
        POS_PAYLOAD     = 3'd5
    } pos_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYNC_FIRST  = 1'd0,
        CFG_SYNC_SECOND = 1'd1
    } cfg_index_t;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'd170;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'd85;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_first;
        logic              frame_last;
    } frame_item_t;

    // One queue entry: either a whole header burst or a single forwarded byte.
    typedef struct packed {
        logic                             is_header;
        logic                             last;
        logic [HDR_BYTES-1:0][BYTE_W-1:0] bytes;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/slfr_stream_if.sv
// Valid/ready stream interface used by both channels of the frame receiver.
// The payload type is a parameter; the structs come from slfr_pkg.
`default_nettype none

interface slfr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/slfr_queue.sv
// Short command queue between the header parser and the output sequencer.
// Register storage with read and write pointers; depends on slfr_pkg for cmd_t.
`default_nettype none

module slfr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire slfr_pkg::cmd_t push_data,
    input  wire logic          pop,
    output slfr_pkg::cmd_t     pop_data,
    output logic               full,
    output logic               empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    slfr_pkg::cmd_t   store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/slfr_front.sv
// Header parser: hunts for the sync pair, collects type and length, counts the payload.
// Pushes one command per header and per forwarded byte; depends on slfr_pkg.
`default_nettype none

module slfr_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [slfr_pkg::BYTE_W-1:0]   rx_byte,
    input  wire logic [slfr_pkg::BYTE_W-1:0]   sync_first,
    input  wire logic [slfr_pkg::BYTE_W-1:0]   sync_second,
    output logic                               push,
    output slfr_pkg::cmd_t                     cmd
);
    localparam int BW = slfr_pkg::BYTE_W;
    localparam int RW = slfr_pkg::REM_W;

    slfr_pkg::pos_t                          pos_reg, pos_next;
    logic [slfr_pkg::STORE_BYTES-1:0][BW-1:0] store_reg, store_next;
    logic [BW-1:0]                           len_hi_reg, len_hi_next;
    logic [RW-1:0]                           rem_reg, rem_next;
    logic                                    rem_done;

    assign rem_done = (rem_reg <= RW'(1));

    always_comb
    begin
        pos_next    = pos_reg;
        store_next  = store_reg;
        len_hi_next = len_hi_reg;
        rem_next    = rem_reg;
        if (accept)
        begin
            unique case (pos_reg)
                slfr_pkg::POS_HUNT_FIRST:
                begin
                    if (rx_byte == sync_first)
                    begin
                        store_next[0] = rx_byte;
                        pos_next      = slfr_pkg::POS_HUNT_SECOND;
                    end
                end
                slfr_pkg::POS_HUNT_SECOND:
                begin
                    if (rx_byte == sync_second)
                    begin
                        store_next[1] = rx_byte;
                        pos_next      = slfr_pkg::POS_TYPE;
                    end
                    else
                    begin
                        pos_next = slfr_pkg::POS_HUNT_FIRST;
                    end
                end
                slfr_pkg::POS_TYPE:
                begin
                    store_next[2] = rx_byte;
                    pos_next      = slfr_pkg::POS_LEN_HI;
                end
                slfr_pkg::POS_LEN_HI:
                begin
                    len_hi_next = rx_byte;
                    pos_next    = slfr_pkg::POS_LEN_LO;
                end
                slfr_pkg::POS_LEN_LO:
                begin
                    rem_next = RW'({len_hi_reg, rx_byte}) + RW'(1);
                    pos_next = slfr_pkg::POS_PAYLOAD;
                end
                default:
                begin
                    if (rem_done)
                    begin
                        rem_next = '0;
                        pos_next = slfr_pkg::POS_HUNT_FIRST;
                    end
                    else
                    begin
                        rem_next = rem_reg - RW'(1);
                        pos_next = slfr_pkg::POS_PAYLOAD;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        push = 1'b0;
        cmd  = '0;
        unique case (pos_reg)
            slfr_pkg::POS_HUNT_FIRST,
            slfr_pkg::POS_HUNT_SECOND,
            slfr_pkg::POS_TYPE,
            slfr_pkg::POS_LEN_HI:
            begin
                push = 1'b0;
            end
            slfr_pkg::POS_LEN_LO:
            begin
                push          = accept;
                cmd.is_header = 1'b1;
                cmd.bytes[0]  = store_reg[0];
                cmd.bytes[1]  = store_reg[1];
                cmd.bytes[2]  = store_reg[2];
                cmd.bytes[3]  = len_hi_reg;
                cmd.bytes[4]  = rx_byte;
            end
            default:
            begin
                push         = accept;
                cmd.last     = rem_done;
                cmd.bytes[0] = rx_byte;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= slfr_pkg::POS_HUNT_FIRST;
            rem_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg  <= store_next;
        len_hi_reg <= len_hi_next;
    end

endmodule

`default_nettype wire

### rtl/slfr_back.sv
// Output sequencer: pops commands and drives the registered frame channel.
// A header command is played out as five requests; depends on slfr_pkg.
`default_nettype none

module slfr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire slfr_pkg::cmd_t                cmd,
    input  wire logic                          cmd_empty,
    output logic                               pop,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output slfr_pkg::frame_item_t              out_item
);
    localparam int BW = slfr_pkg::BYTE_W;
    localparam int HW = slfr_pkg::HDR_BYTES - 1;
    localparam int CW = slfr_pkg::HDR_CNT_W;

    logic                  valid_reg, valid_next;
    slfr_pkg::frame_item_t item_reg, item_next;
    logic [HW-1:0][BW-1:0] hdr_reg, hdr_next;
    logic [CW-1:0]         hdr_cnt_reg, hdr_cnt_next;
    logic                  can_load;

    assign can_load  = !valid_reg || out_ready;
    assign pop       = can_load && (hdr_cnt_reg == '0) && !cmd_empty;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        item_next    = item_reg;
        hdr_next     = hdr_reg;
        hdr_cnt_next = hdr_cnt_reg;
        if (can_load)
        begin
            priority if (hdr_cnt_reg != '0)
            begin
                valid_next             = 1'b1;
                item_next.frame_byte   = hdr_reg[0];
                item_next.frame_first  = 1'b0;
                item_next.frame_last   = 1'b0;
                hdr_next               = hdr_reg >> BW;
                hdr_cnt_next           = hdr_cnt_reg - 1'b1;
            end
            else if (!cmd_empty)
            begin
                valid_next            = 1'b1;
                item_next.frame_byte  = cmd.bytes[0];
                item_next.frame_first = cmd.is_header;
                item_next.frame_last  = cmd.last && !cmd.is_header;
                if (cmd.is_header)
                begin
                    hdr_next     = cmd.bytes[slfr_pkg::HDR_BYTES-1:1];
                    hdr_cnt_next = CW'(HW);
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            hdr_cnt_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            hdr_cnt_reg <= hdr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hdr_reg  <= hdr_next;
    end

endmodule

`default_nettype wire

### rtl/sync_length_frame_receiver.sv
// Top level of the sync/length frame receiver: configuration registers, parser, queue, sequencer.
// Depends on slfr_pkg, slfr_stream_if, slfr_front, slfr_queue and slfr_back.
//
// Usage: received bytes arrive one request at a time on the rx channel. The block
// hunts for the two sync bytes, reads a type byte and a 16-bit big-endian length,
// and then sends the frame on the frame channel: the five header bytes as a burst,
// then each payload byte and the check byte, which carries frame_last. The first
// sync byte carries frame_first. Bytes outside a frame produce nothing.
// The sync bytes are set through cfg_we, cfg_index and cfg_data; the user must set them
// only while idle, as the block itself does not enforce it. Throughput: one rx request
// per cycle while the queue is not full. A byte that finds the sequencer idle passes
// through a queue entry and then the output register to the frame channel; the header
// burst of five requests follows the length low byte the same way, and the payload bytes
// queue behind it until the hunt for the next header drains the queue. Six queue entries
// hold that backlog at full rate; rx.ready drops only while the queue is full, which with
// the default depth happens only when the frame receiver stalls and backs up into rx.
// Reset clears the hunt, the queue and the output register; the sync bytes
// return to 170 and 85.
`default_nettype none

module sync_length_frame_receiver #(
    parameter int QUEUE_DEPTH = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [slfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [slfr_pkg::BYTE_W-1:0]      cfg_data,
    slfr_stream_if.sink                           rx,
    slfr_stream_if.source                         frame
);
    logic [slfr_pkg::BYTE_W-1:0] sync_first_reg, sync_first_next;
    logic [slfr_pkg::BYTE_W-1:0] sync_second_reg, sync_second_next;
    logic                        rx_accept;
    logic                        push;
    logic                        pop;
    logic                        q_full;
    logic                        q_empty;
    slfr_pkg::cmd_t              push_cmd;
    slfr_pkg::cmd_t              pop_cmd;
    slfr_pkg::rx_item_t          rx_item;
    slfr_pkg::frame_item_t       out_item;

    assign rx.ready      = !q_full;
    assign rx_accept     = rx.valid && !q_full;
    assign rx_item       = rx.payload;
    assign frame.payload = out_item;

    always_comb
    begin
        sync_first_next  = sync_first_reg;
        sync_second_next = sync_second_reg;
        if (cfg_we)
        begin
            unique case (slfr_pkg::cfg_index_t'(cfg_index))
                slfr_pkg::CFG_SYNC_FIRST:  sync_first_next  = cfg_data;
                slfr_pkg::CFG_SYNC_SECOND: sync_second_next = cfg_data;
                default:                   sync_first_next  = sync_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= slfr_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= slfr_pkg::SYNC_SECOND_RESET;
        end
        else
        begin
            sync_first_reg  <= sync_first_next;
            sync_second_reg <= sync_second_next;
        end
    end

    slfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (rx_accept),
        .rx_byte     (rx_item.rx_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .push        (push),
        .cmd         (push_cmd)
    );

    slfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    slfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_empty (q_empty),
        .pop       (pop),
        .out_ready (frame.ready),
        .out_valid (frame.valid),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

### rtl/slfr_checker.sv
// Port-level checks for the sync/length frame receiver, bound to the top level.
// Sees only the frame channel handshake and payload; depends on slfr_pkg.
`default_nettype none

module slfr_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        frame_valid,
    input wire logic                        frame_ready,
    input wire logic [slfr_pkg::BYTE_W-1:0] frame_byte,
    input wire logic                        frame_first,
    input wire logic                        frame_last
);
    // A stalled request keeps its valid and its payload.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=>
            frame_valid && $stable(frame_byte) && $stable(frame_first) && $stable(frame_last))
        else $error("frame request changed while stalled");

    // A byte cannot both start and end a frame.
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> !(frame_first && frame_last))
        else $error("frame_first and frame_last set together");

    // The header burst follows the first sync byte, so the next request never starts a frame.
    a_first_then_header: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && frame_first |=> !(frame_valid && frame_first))
        else $error("two frame starts in a row");

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !frame_valid)
        else $error("frame request present after reset");

endmodule

bind sync_length_frame_receiver slfr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.payload.frame_byte),
    .frame_first (frame.payload.frame_first),
    .frame_last  (frame.payload.frame_last)
);

`default_nettype wire
